### hdl/bds_pkg.sv
// ----------------------------------------------------------------------------
// bds_pkg: shared types for the de Casteljau split block
// Coordinate and parameter widths, point and pyramid types.
// ----------------------------------------------------------------------------
package bds_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int T_FRAC_BITS = 16;
    localparam int T_WIDTH     = T_FRAC_BITS + 1;
    localparam int NUM_POINTS  = 4;

    localparam logic [T_WIDTH-1:0] T_ONE = T_WIDTH'(1) << T_FRAC_BITS;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic        [T_WIDTH-1:0]     t_tpar;
    typedef logic        [1:0]             t_idx;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_pt;

    // lv[level][j]: level 0 holds the control points
    typedef struct packed {
        t_idx                                  deg;
        t_tpar                                 t;
        t_pt [NUM_POINTS-1:0][NUM_POINTS-1:0]  lv;
    } t_pyr;

endpackage

### hdl/bezier_decasteljau_split_top.sv
// ----------------------------------------------------------------------------
// bezier_decasteljau_split_top: Bezier split by de Casteljau subdivision
// Degree 1..3 curve in, left and right half control points out.
// ----------------------------------------------------------------------------
// Path: input is registered in stages s1, s2, s3, then in the sequencer output.
// Throughput: the result sequencer emits one point pair per cycle while
// i_stall is low, degree+1 pairs per curve; a new curve is taken every
// cycle while the pipeline has room.
// Reset: synchronous, active low; clears all stage valids, payload is kept.
// ----------------------------------------------------------------------------
module bezier_decasteljau_split_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // input channel
    input  logic            i_valid,
    output logic            o_stall,
    input  bds_pkg::t_idx   i_curve_degree,
    input  bds_pkg::t_tpar  i_t_param,
    input  bds_pkg::t_coord i_p0_x,
    input  bds_pkg::t_coord i_p0_y,
    input  bds_pkg::t_coord i_p1_x,
    input  bds_pkg::t_coord i_p1_y,
    input  bds_pkg::t_coord i_p2_x,
    input  bds_pkg::t_coord i_p2_y,
    input  bds_pkg::t_coord i_p3_x,
    input  bds_pkg::t_coord i_p3_y,
    // result channel
    output logic            o_valid,
    input  logic            i_stall,
    output bds_pkg::t_idx   o_point_index,
    output bds_pkg::t_coord o_left_x,
    output bds_pkg::t_coord o_left_y,
    output bds_pkg::t_coord o_right_x,
    output bds_pkg::t_coord o_right_y,
    output logic            o_last_point
);
    import bds_pkg::*;

    // Three pipeline stages, one pyramid level each. Each stage carries the
    // whole pyramid built so far; the lanes fill in the next level.
    t_pyr   r_s1, n_s1;
    t_pyr   r_s2, n_s2;
    t_pyr   r_s3, n_s3;
    logic   r_v1, r_v2, r_v3;
    logic   w_en1, w_en2, w_en3;
    logic   w_take;
    t_tpar  w_t;

    t_coord w_p_x  [NUM_POINTS];
    t_coord w_p_y  [NUM_POINTS];
    t_coord w_l1_x [3];
    t_coord w_l1_y [3];
    t_coord w_l2_x [2];
    t_coord w_l2_y [2];
    t_coord w_l3_x;
    t_coord w_l3_y;

    // t above one saturates to one
    assign w_t = (i_t_param > T_ONE) ? T_ONE : i_t_param;

    assign w_p_x[0] = i_p0_x;
    assign w_p_y[0] = i_p0_y;
    assign w_p_x[1] = i_p1_x;
    assign w_p_y[1] = i_p1_y;
    assign w_p_x[2] = i_p2_x;
    assign w_p_y[2] = i_p2_y;
    assign w_p_x[3] = i_p3_x;
    assign w_p_y[3] = i_p3_y;

    // Level 1 lanes work on the input ports directly. Lanes past the degree
    // produce values that the sequencer never selects.
    for (genvar j = 0; j < 3; j++) begin : g_l1
        bds_lerp u_x (.i_a(w_p_x[j]), .i_b(w_p_x[j+1]), .i_t(w_t), .o_y(w_l1_x[j]));
        bds_lerp u_y (.i_a(w_p_y[j]), .i_b(w_p_y[j+1]), .i_t(w_t), .o_y(w_l1_y[j]));
    end

    for (genvar j = 0; j < 2; j++) begin : g_l2
        bds_lerp u_x (.i_a(r_s1.lv[1][j].x), .i_b(r_s1.lv[1][j+1].x),
                      .i_t(r_s1.t), .o_y(w_l2_x[j]));
        bds_lerp u_y (.i_a(r_s1.lv[1][j].y), .i_b(r_s1.lv[1][j+1].y),
                      .i_t(r_s1.t), .o_y(w_l2_y[j]));
    end

    bds_lerp u_l3_x (.i_a(r_s2.lv[2][0].x), .i_b(r_s2.lv[2][1].x),
                     .i_t(r_s2.t), .o_y(w_l3_x));
    bds_lerp u_l3_y (.i_a(r_s2.lv[2][0].y), .i_b(r_s2.lv[2][1].y),
                     .i_t(r_s2.t), .o_y(w_l3_y));

    always_comb begin
        n_s1     = '0;
        n_s1.deg = i_curve_degree;
        n_s1.t   = w_t;
        for (int j = 0; j < NUM_POINTS; j++) begin
            n_s1.lv[0][j].x = w_p_x[j];
            n_s1.lv[0][j].y = w_p_y[j];
        end
        for (int j = 0; j < 3; j++) begin
            n_s1.lv[1][j].x = w_l1_x[j];
            n_s1.lv[1][j].y = w_l1_y[j];
        end

        n_s2 = r_s1;
        for (int j = 0; j < 2; j++) begin
            n_s2.lv[2][j].x = w_l2_x[j];
            n_s2.lv[2][j].y = w_l2_y[j];
        end

        n_s3             = r_s2;
        n_s3.lv[3][0].x  = w_l3_x;
        n_s3.lv[3][0].y  = w_l3_y;
    end

    // A stage moves when it is empty or when the stage after it moves.
    assign w_en3   = !r_v3 || w_take;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_stall = !w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
        if (w_en1) begin
            r_s1 <= n_s1;
        end
        if (w_en2) begin
            r_s2 <= n_s2;
        end
        if (w_en3) begin
            r_s3 <= n_s3;
        end
    end

    // Merge: picks left point k from the pyramid edge lv[k][0] and right
    // point k from lv[deg-k][k], one transfer per point.
    bds_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pyr         (r_s3),
        .i_pyr_valid   (r_v3),
        .o_take        (w_take),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_point_index (o_point_index),
        .o_left_x      (o_left_x),
        .o_left_y      (o_left_y),
        .o_right_x     (o_right_x),
        .o_right_y     (o_right_y),
        .o_last_point  (o_last_point)
    );

endmodule

### hdl/bds_lerp.sv
// ----------------------------------------------------------------------------
// bds_lerp: one interpolation lane
// y = a + round_half_up(t * (b - a) / 2^T_FRAC_BITS) on one coordinate.
// ----------------------------------------------------------------------------
module bds_lerp (
    input  bds_pkg::t_coord i_a,
    input  bds_pkg::t_coord i_b,
    input  bds_pkg::t_tpar  i_t,
    output bds_pkg::t_coord o_y
);
    import bds_pkg::*;

    localparam int PW = COORD_WIDTH + T_WIDTH + 2;
    localparam logic signed [PW-1:0] HALF = PW'(1) << (T_FRAC_BITS - 1);

    logic signed [COORD_WIDTH:0] w_d;
    logic signed [T_WIDTH:0]     w_t;
    logic signed [PW-1:0]        w_prod;
    logic signed [PW-1:0]        w_rnd;
    logic signed [PW-1:0]        w_sh;

    assign w_d    = $signed({i_b[COORD_WIDTH-1], i_b}) - $signed({i_a[COORD_WIDTH-1], i_a});
    assign w_t    = $signed({1'b0, i_t});
    assign w_prod = PW'(w_d) * PW'(w_t);
    assign w_rnd  = w_prod + HALF;
    assign w_sh   = w_rnd >>> T_FRAC_BITS;
    // result lies between a and b, so the low bits are exact
    assign o_y    = t_coord'(i_a + w_sh[COORD_WIDTH-1:0]);

endmodule

### hdl/bds_merge.sv
// ----------------------------------------------------------------------------
// bds_merge: result sequencer
// Holds a finished pyramid and emits left/right point pairs, one per transfer.
// ----------------------------------------------------------------------------
module bds_merge (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bds_pkg::t_pyr   i_pyr,
    input  logic            i_pyr_valid,
    output logic            o_take,
    input  logic            i_stall,
    output logic            o_valid,
    output bds_pkg::t_idx   o_point_index,
    output bds_pkg::t_coord o_left_x,
    output bds_pkg::t_coord o_left_y,
    output bds_pkg::t_coord o_right_x,
    output bds_pkg::t_coord o_right_y,
    output logic            o_last_point
);
    import bds_pkg::*;

    t_pyr   r_hold, n_hold;
    t_idx   r_k, n_k;
    logic   r_valid, n_valid;
    logic   r_last, n_last;
    t_pt    r_left, n_left;
    t_pt    r_right, n_right;
    logic   w_more;
    logic   w_adv;

    assign w_more = r_valid && !r_last;
    assign w_adv  = !r_valid || !i_stall;
    assign o_take = w_adv && !w_more && i_pyr_valid;

    always_comb begin
        t_pyr src;
        src     = w_more ? r_hold : i_pyr;
        n_hold  = r_hold;
        n_k     = r_k;
        n_valid = r_valid;
        if (w_adv) begin
            if (w_more) begin
                n_k = r_k + 2'd1;
            end else begin
                n_hold = i_pyr;
                n_k    = '0;
            end
            n_valid = w_more || i_pyr_valid;
        end
        n_last  = (n_k == src.deg);
        n_left  = src.lv[n_k][0];
        n_right = src.lv[t_idx'(src.deg - n_k)][n_k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (w_adv) begin
            r_hold  <= n_hold;
            r_k     <= n_k;
            r_last  <= n_last;
            r_left  <= n_left;
            r_right <= n_right;
        end
    end

    assign o_valid       = r_valid;
    assign o_point_index = r_k;
    assign o_left_x      = r_left.x;
    assign o_left_y      = r_left.y;
    assign o_right_x     = r_right.x;
    assign o_right_y     = r_right.y;
    assign o_last_point  = r_last;

endmodule

### hdl/bds_checker.sv
// ----------------------------------------------------------------------------
// bds_checker: port-level checks for the split block
// Result sequencing and reset behavior seen on the top level ports.
// ----------------------------------------------------------------------------
module bds_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_valid,
    input logic            i_stall,
    input bds_pkg::t_idx   o_point_index,
    input bds_pkg::t_coord o_left_x,
    input logic            o_last_point
);
    import bds_pkg::*;

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_point_index) && $stable(o_left_x))
        else $error("stalled result changed");

    a_next_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_point
        |=> o_valid && o_point_index == t_idx'($past(o_point_index) + 2'd1))
        else $error("point sequence broken");

    a_new_curve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last_point |=> !o_valid || o_point_index == 2'd0)
        else $error("new curve does not start at point zero");

    a_index_three_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_point_index == 2'd3 |-> o_last_point)
        else $error("point three not flagged last");

endmodule

bind bezier_decasteljau_split_top bds_checker u_bds_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_point_index (o_point_index),
    .o_left_x      (o_left_x),
    .o_last_point  (o_last_point)
);
